>>> rtl/core/qtcf_pkg.sv
// shared types and constants of the quote tick cache filter
// no dependencies; compiled before every other file of the block

package qtcf_pkg;

    localparam int SYM_W = 14;
    localparam int TYPE_W = 3;
    localparam int WORD_W = 32;
    localparam int STATUS_W = 3;

    // tick type codes
    localparam logic [TYPE_W-1:0] TT_UNKNOWN = 3'd0;
    localparam logic [TYPE_W-1:0] TT_BID = 3'd1;
    localparam logic [TYPE_W-1:0] TT_ASK = 3'd2;
    localparam logic [TYPE_W-1:0] TT_TRADE = 3'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_TIME = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REPEAT = 3'd5;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol_index;
        logic [TYPE_W-1:0] tick_type;
        logic [WORD_W-1:0] price;
        logic [WORD_W-1:0] quantity;
        logic [WORD_W-1:0] stamp_seconds;
        logic              bad_mark;
        logic              halted_mark;
    } t_tick;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   price_out;
        logic [WORD_W-1:0]   quantity_out;
    } t_result;

endpackage

>>> rtl/core/qtcf_if.sv
// valid/ready channel interfaces for ticks in and results out
// depends on qtcf_pkg for the payload types

interface qtcf_tick_if;
    logic              valid;
    logic              ready;
    qtcf_pkg::t_tick   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qtcf_result_if;
    logic              valid;
    logic              ready;
    qtcf_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/qtcf_ram.sv
// generic single-port synchronous ram with registered read data
// no dependencies

module qtcf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/quote_tick_cache_filter.sv
// top level of the quote tick cache filter: validation, cache lookup and write
// depends on qtcf_pkg, qtcf_if and qtcf_ram

// Every accepted tick yields exactly one result item, in order. Ticks stream at one item
// per cycle while results are taken and no clearing pass runs. The tick lands in the slot
// decode register when it is accepted, then passes the cache access in the single ram port
// and the result register, where its result is offered. The bid, ask and trade caches share
// one ram of 3*NUM_SYMBOLS rows of {price, size}; each tick uses the port at most once,
// either a write (priced tick) or a read (size-only tick), so ticks on the same symbol need
// no forwarding. After reset a clearing pass zeroes every row of the ram, during which no
// tick is accepted. symbol_index is reduced modulo NUM_SYMBOLS by a reciprocal
// multiply when NUM_SYMBOLS is smaller than the index range.

module quote_tick_cache_filter #(
    parameter int NUM_SYMBOLS = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    qtcf_tick_if.sink            i_tick,
    qtcf_result_if.source        o_result
);

    localparam int DEPTH = 3 * NUM_SYMBOLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ENTRY_W = 2 * qtcf_pkg::WORD_W;
    localparam int IDX_RANGE = 1 << qtcf_pkg::SYM_W;
    localparam int Q_MAX = (IDX_RANGE - 1) / NUM_SYMBOLS;
    localparam int Q_W = (Q_MAX > 0) ? $clog2(Q_MAX + 1) : 1;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

    // how an item is handled past decode
    localparam logic [1:0] KIND_FINAL = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LOOK = 2'd2;

    // clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // handshake chain
    logic w_take_out;
    logic w_b_free;
    logic w_a_free;
    logic w_acc;
    logic w_mem_go;

    // decode of the incoming tick
    logic [1:0]                     w_kind;
    logic [qtcf_pkg::STATUS_W-1:0]  w_status;
    logic [qtcf_pkg::WORD_W-1:0]    w_price;
    logic [ADDR_W-1:0]              w_base;
    logic [Q_W-1:0]                 w_q;

    // stage a: slot decode
    logic                           r_a_valid;
    logic [1:0]                     r_a_kind;
    logic [qtcf_pkg::STATUS_W-1:0]  r_a_status;
    logic [qtcf_pkg::WORD_W-1:0]    r_a_price;
    logic [qtcf_pkg::WORD_W-1:0]    r_a_qty;
    logic [ADDR_W-1:0]              r_a_idx_base;
    logic [Q_W-1:0]                 r_a_q;
    logic [ADDR_W-1:0]              w_q_n;
    logic [ADDR_W-1:0]              w_addr;

    // stage b: cache data back
    logic                           r_b_valid;
    logic [1:0]                     r_b_kind;
    logic [qtcf_pkg::STATUS_W-1:0]  r_b_status;
    logic [qtcf_pkg::WORD_W-1:0]    r_b_price;
    logic [qtcf_pkg::WORD_W-1:0]    r_b_qty;

    // output register
    logic                           r_out_valid;
    logic [qtcf_pkg::STATUS_W-1:0]  r_out_status;
    logic [qtcf_pkg::WORD_W-1:0]    r_out_price;
    logic [qtcf_pkg::WORD_W-1:0]    r_out_qty;

    // ram port
    logic               w_ram_en;
    logic               w_ram_we;
    logic [ADDR_W-1:0]  w_ram_addr;
    logic [ENTRY_W-1:0] w_ram_wdata;
    logic [ENTRY_W-1:0] w_ram_rdata;

    // each stage moves on when the one after it has room
    assign w_take_out = !r_out_valid || o_result.ready;
    assign w_b_free = !r_b_valid || w_take_out;
    assign w_a_free = !r_a_valid || w_b_free;
    assign i_tick.ready = !r_clr_busy && w_a_free;
    assign w_acc = i_tick.valid && i_tick.ready;
    assign w_mem_go = r_a_valid && w_b_free;

    // checks in priority order; halted ticks skip the price and cache checks
    always_comb begin
        w_kind = KIND_FINAL;
        w_status = qtcf_pkg::ST_OK;
        w_price = i_tick.data.price;
        if (i_tick.data.bad_mark) begin
            w_status = qtcf_pkg::ST_BAD;
        end else if (i_tick.data.stamp_seconds == '0) begin
            w_status = qtcf_pkg::ST_ZERO_TIME;
        end else if (i_tick.data.halted_mark) begin
            w_status = qtcf_pkg::ST_OK;
        end else if (i_tick.data.price == '0 && i_tick.data.quantity == '0) begin
            w_status = qtcf_pkg::ST_EMPTY;
        end else if (i_tick.data.tick_type == qtcf_pkg::TT_UNKNOWN) begin
            w_status = qtcf_pkg::ST_UNKNOWN;
        end else if (i_tick.data.tick_type[2]) begin
            // other known types pass unchanged
            w_status = qtcf_pkg::ST_OK;
        end else if (i_tick.data.price != '0) begin
            w_kind = KIND_WRITE;
        end else begin
            w_kind = KIND_LOOK;
        end
    end

    // cache region of the tick type: bid rows first, then ask, then trade
    always_comb begin
        unique case (i_tick.data.tick_type)
            qtcf_pkg::TT_ASK:   w_base = ADDR_W'(NUM_SYMBOLS);
            qtcf_pkg::TT_TRADE: w_base = ADDR_W'(2 * NUM_SYMBOLS);
            default:            w_base = '0;
        endcase
    end

    // quotient of symbol_index by NUM_SYMBOLS; the reciprocal is exact over the index range
    if (NUM_SYMBOLS < IDX_RANGE) begin : g_mod
        localparam int SH = qtcf_pkg::SYM_W + $clog2(NUM_SYMBOLS);
        localparam logic [63:0] RECIP = ((64'd1 << SH) + NUM_SYMBOLS - 1) / NUM_SYMBOLS;
        localparam int PROD_W = qtcf_pkg::SYM_W + 16;
        logic [PROD_W-1:0] w_prod;
        assign w_prod = PROD_W'(i_tick.data.symbol_index) * PROD_W'(RECIP);
        assign w_q = Q_W'(w_prod >> SH);
    end else begin : g_nomod
        assign w_q = '0;
    end

    // row = index + region base - quotient * NUM_SYMBOLS, modulo the address width
    assign w_q_n = ADDR_W'(r_a_q * NUM_SYMBOLS);
    assign w_addr = r_a_idx_base - w_q_n;

    // clearing pass, then at most one access per item
    assign w_ram_en = r_clr_busy || (w_mem_go && r_a_kind != KIND_FINAL);
    assign w_ram_we = r_clr_busy || (r_a_kind == KIND_WRITE);
    assign w_ram_addr = r_clr_busy ? r_clr_addr : w_addr;
    assign w_ram_wdata = r_clr_busy ? '0 : {r_a_price, r_a_qty};

    qtcf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_cache (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_a_free) begin
                r_a_valid <= w_acc;
            end
            if (w_b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (w_take_out) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_kind <= w_kind;
            r_a_status <= w_status;
            // rejected items carry zero fields
            r_a_price <= (w_status == qtcf_pkg::ST_OK) ? w_price : '0;
            r_a_qty <= (w_status == qtcf_pkg::ST_OK) ? i_tick.data.quantity : '0;
            r_a_idx_base <= ADDR_W'(i_tick.data.symbol_index) + w_base;
            r_a_q <= w_q;
        end
        if (w_mem_go) begin
            r_b_kind <= r_a_kind;
            r_b_status <= r_a_status;
            r_b_price <= r_a_price;
            r_b_qty <= r_a_qty;
        end
        if (w_take_out && r_b_valid) begin
            if (r_b_kind == KIND_LOOK) begin
                // size-only tick: a repeat of the cached size gives a repeat result with zero fields
                if (r_b_qty == w_ram_rdata[qtcf_pkg::WORD_W-1:0]) begin
                    r_out_status <= qtcf_pkg::ST_REPEAT;
                    r_out_price <= '0;
                    r_out_qty <= '0;
                end else begin
                    r_out_status <= qtcf_pkg::ST_OK;
                    r_out_price <= w_ram_rdata[ENTRY_W-1:qtcf_pkg::WORD_W];
                    r_out_qty <= r_b_qty;
                end
            end else begin
                r_out_status <= r_b_status;
                r_out_price <= r_b_price;
                r_out_qty <= r_b_qty;
            end
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data.status = r_out_status;
    assign o_result.data.price_out = r_out_price;
    assign o_result.data.quantity_out = r_out_qty;

    // nothing is in flight while the cache is being cleared
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_a_valid && !r_b_valid && !r_out_valid))
        else $error("item in flight during cache clearing");

    // the clearing pass ends only after the last row
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> ($past(r_clr_addr) == CLR_LAST))
        else $error("cache clearing ended early");

    // any result other than accepted carries zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.status != qtcf_pkg::ST_OK)
            |-> (o_result.data.price_out == '0 && o_result.data.quantity_out == '0))
        else $error("rejected item with nonzero fields");

    // a cache access only comes from an item leaving stage a
    a_ram_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_en && !r_clr_busy) |-> (r_a_valid && w_b_free))
        else $error("cache access without an item");

endmodule
